// ----- rtl/hbs_pkg.sv -----
package hbs_pkg;

  localparam int MAX_SIDE_DEF = 129;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W = 24;
  localparam int GRID_REG_W = 8;
  localparam int IDX_IN_W = 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_LENGTH = 2'd1;
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -24'sh800000;

endpackage

// ----- rtl/hbs_in_if.sv -----
interface hbs_in_if #(
  parameter int CW = 17
);
  logic valid;
  logic ready;
  logic mode;
  logic [7:0] write_row;
  logic [7:0] write_column;
  logic signed [23:0] write_value;
  logic [CW-1:0] coord_u;
  logic [CW-1:0] coord_v;
  modport source (output valid, mode, write_row, write_column, write_value,
                  coord_u, coord_v, input ready);
  modport sink (input valid, mode, write_row, write_column, write_value,
                coord_u, coord_v, output ready);
endinterface

// ----- rtl/hbs_out_if.sv -----
interface hbs_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

// ----- rtl/hbs_cfg_if.sv -----
interface hbs_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/heightmap_bilinear_sampler_core.sv -----
// bilinear height sampler over a grid of signed q15.8 samples held in four
// parity banks (row parity x column parity), so the four neighbours of a
// query are read in the same cycle. one transaction enters every cycle
// while the pipeline advances; a query's height passes the stages below
// into the output register and is offered from then on, a write gives nothing.
// the pipeline is: coordinate scale, index/weight split and bank address,
// bank read, four column products, row blend round, vertical products,
// round/offset/saturate. the whole pipeline advances together and holds
// when the output register is full and not taken; nothing is lost.
// a clamped neighbour at the grid edge repeats the sample on that side.
// writes land in the banks at stage 2, in order with queries.
module heightmap_bilinear_sampler_core
  import hbs_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hbs_in_if.sink   in_ch,
  hbs_out_if.source out_ch,
  hbs_cfg_if.sink  cfg_ch
);
  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 1;
  localparam int SW = $clog2(MAX_SIDE + 1);         // side value width
  localparam int IW = $clog2(MAX_SIDE);             // index width
  localparam int HS = (MAX_SIDE + 1) / 2;           // entries per bank side
  localparam int BD = HS * HS;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int PW = CW + SW;                      // product width
  localparam int WW = F + 1;                        // weight incl. one
  localparam int MW = SAMPLE_W + WW + 2;            // blend width

  // configuration
  logic [GRID_REG_W-1:0] gw_r, gl_r;
  logic signed [SAMPLE_W-1:0] base_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GRID_REG_W'(129);
      gl_r <= GRID_REG_W'(129);
      base_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GRID_WIDTH: gw_r <= cfg_ch.data[GRID_REG_W-1:0];
        REG_GRID_LENGTH: gl_r <= cfg_ch.data[GRID_REG_W-1:0];
        REG_BASE_HEIGHT: base_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] side_of(input logic [GRID_REG_W-1:0] g);
    if (g < 2) return SW'(2);
    if (32'(g) > MAX_SIDE) return SW'(MAX_SIDE);
    return SW'(g);
  endfunction

  // pipeline advance: output register empty or being taken
  logic adv;
  logic [5:1] v_r;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: scale
  logic q1_r, w1_r;
  logic [PW-1:0] pu1_r, pv1_r;
  logic [SW-1:0] cols1_r, rows1_r;
  logic [IDX_IN_W-1:0] wr1_r, wc1_r;
  logic signed [SAMPLE_W-1:0] wv1_r;
  logic [CW-1:0] cu, cv;
  logic [SW-1:0] cols, rows;
  assign cols = side_of(gw_r);
  assign rows = side_of(gl_r);
  assign cu = (in_ch.coord_u > CW'(1 << F)) ? CW'(1 << F) : in_ch.coord_u;
  assign cv = (in_ch.coord_v > CW'(1 << F)) ? CW'(1 << F) : in_ch.coord_v;
  always_ff @(posedge clk) begin
    if (adv) begin
      pu1_r <= PW'(cu) * PW'(cols);
      pv1_r <= PW'(cv) * PW'(rows);
      cols1_r <= cols; rows1_r <= rows;
      q1_r <= in_ch.mode == MODE_QUERY;
      w1_r <= in_ch.mode == MODE_WRITE && 32'(in_ch.write_row) < MAX_SIDE
              && 32'(in_ch.write_column) < MAX_SIDE;
      wr1_r <= in_ch.write_row; wc1_r <= in_ch.write_column;
      wv1_r <= in_ch.write_value;
    end
  end

  // stage 2: split, clamp, bank addresses; writes go here
  localparam int XW = PW - F + 1;                   // signed index width
  logic signed [XW-1:0] c0, r0;
  logic [F-1:0] fu, fv;
  logic [WW-1:0] wu, wvt;
  logic [IW-1:0] ca, cb, ra, rb;

  function automatic logic [IW-1:0] clampi(input logic signed [XW-1:0] i,
                                           input logic [SW-1:0] side);
    if (i < 0) return '0;
    if (i > $signed({1'b0, side}) - 1) return IW'(side - 1'b1);
    return IW'(i);
  endfunction

  always_comb begin
    fu = pu1_r[F-1:0];
    fv = pv1_r[F-1:0];
    c0 = $signed({1'b0, pu1_r[PW-1:F]});
    r0 = $signed({1'b0, pv1_r[PW-1:F]});
    if (fu[F-1]) wu = WW'(fu) - WW'(1 << (F-1));
    else begin wu = WW'(fu) + WW'(1 << (F-1)); c0 = c0 - 1'b1; end
    if (fv[F-1]) wvt = WW'(fv) - WW'(1 << (F-1));
    else begin wvt = WW'(fv) + WW'(1 << (F-1)); r0 = r0 - 1'b1; end
    ca = clampi(c0, cols1_r);
    cb = clampi(c0 + 1'b1, cols1_r);
    ra = clampi(r0, rows1_r);
    rb = clampi(r0 + 1'b1, rows1_r);
  end

  // each bank is addressed by halved row and column; for each parity
  // the corner with that parity is chosen
  logic [BAW-1:0] baddr [4];
  logic [IW-1:0] rsel [2], csel [2];
  always_comb begin
    rsel[0] = ra[0] ? rb : ra;  rsel[1] = ra[0] ? ra : rb;
    csel[0] = ca[0] ? cb : ca;  csel[1] = ca[0] ? ca : cb;
    for (int b = 0; b < 4; b++)
      baddr[b] = BAW'(32'(rsel[b/2] >> 1) * HS + 32'(csel[b%2] >> 1));
  end

  logic signed [SAMPLE_W-1:0] bank0 [BD];
  logic signed [SAMPLE_W-1:0] bank1 [BD];
  logic signed [SAMPLE_W-1:0] bank2 [BD];
  logic signed [SAMPLE_W-1:0] bank3 [BD];
  logic signed [SAMPLE_W-1:0] rd_r [4];
  logic [BAW-1:0] waddr;
  logic [1:0] wbank;
  assign waddr = BAW'(32'(wr1_r >> 1) * HS + 32'(wc1_r >> 1));
  assign wbank = {wr1_r[0], wc1_r[0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (w1_r && v_r[1] && wbank == 2'd0) bank0[waddr] <= wv1_r;
      if (w1_r && v_r[1] && wbank == 2'd1) bank1[waddr] <= wv1_r;
      if (w1_r && v_r[1] && wbank == 2'd2) bank2[waddr] <= wv1_r;
      if (w1_r && v_r[1] && wbank == 2'd3) bank3[waddr] <= wv1_r;
    end
  end

  logic [1:0] par2_r;
  logic rdup2_r, cdup2_r;
  logic [WW-1:0] wu2_r, wv2_r, wv3_r;
  logic q2_r;
  // stage 3: bank read (registered)
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r[0] <= bank0[baddr[0]];
      rd_r[1] <= bank1[baddr[1]];
      rd_r[2] <= bank2[baddr[2]];
      rd_r[3] <= bank3[baddr[3]];
      par2_r <= {ra[0], ca[0]};
      rdup2_r <= ra == rb;
      cdup2_r <= ca == cb;
      wu2_r <= wu; wv2_r <= wvt;
      q2_r <= q1_r;
    end
  end

  logic signed [SAMPLE_W-1:0] s00, s01, s10, s11;
  always_comb begin
    // bank index = {row parity, column parity}; a clamped corner reuses
    // the bank of the corner it repeats
    s00 = rd_r[{par2_r[1], par2_r[0]}];
    s01 = rd_r[{par2_r[1], cdup2_r ? par2_r[0] : ~par2_r[0]}];
    s10 = rd_r[{rdup2_r ? par2_r[1] : ~par2_r[1], par2_r[0]}];
    s11 = rd_r[{rdup2_r ? par2_r[1] : ~par2_r[1], cdup2_r ? par2_r[0] : ~par2_r[0]}];
  end

  // stage 4: column products
  logic signed [MW-1:0] p00_r, p01_r, p10_r, p11_r;
  logic q3_r;
  logic signed [WW:0] wus, wuc;
  assign wus = $signed({1'b0, wu2_r});
  assign wuc = $signed((WW+1)'(1 << F)) - wus;
  always_ff @(posedge clk) begin
    if (adv) begin
      p00_r <= MW'(s00 * wuc); p01_r <= MW'(s01 * wus);
      p10_r <= MW'(s10 * wuc); p11_r <= MW'(s11 * wus);
      wv3_r <= wv2_r; q3_r <= q2_r;
    end
  end

  // stage 5: row blends rounded to q15.8
  logic signed [MW-1:0] sa, sb;
  logic signed [SAMPLE_W:0] f1_r, f2_r;
  logic q4_r;
  logic [WW-1:0] wv4_r;
  assign sa = p00_r + p01_r + MW'(1 << (F-1));
  assign sb = p10_r + p11_r + MW'(1 << (F-1));
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= (SAMPLE_W+1)'(sa >>> F);
      f2_r <= (SAMPLE_W+1)'(sb >>> F);
      wv4_r <= wv3_r; q4_r <= q3_r;
    end
  end

  // stage 6: vertical products
  logic signed [WW:0] wvs, wvc;
  logic signed [MW-1:0] m1_r, m2_r;
  logic q5_r;
  assign wvs = $signed({1'b0, wv4_r});
  assign wvc = $signed((WW+1)'(1 << F)) - wvs;
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= MW'(f1_r * wvc);
      m2_r <= MW'(f2_r * wvs);
      q5_r <= q4_r;
    end
  end

  // stage 7: round, add base, saturate, output register
  logic signed [MW-1:0] mx;
  logic signed [SAMPLE_W+1:0] res;
  assign mx = m1_r + m2_r + MW'(1 << (F-1));
  assign res = (SAMPLE_W+2)'(mx >>> F) + (SAMPLE_W+2)'(base_r);
  logic valid_r;
  logic signed [SAMPLE_W-1:0] h_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (res > (SAMPLE_W+2)'(SAT_MAX)) h_r <= SAT_MAX;
      else if (res < (SAMPLE_W+2)'(SAT_MIN)) h_r <= SAT_MIN;
      else h_r <= SAMPLE_W'(res);
    end
  end

  // valid chain; query flags ride alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[4:1], in_ch.valid};
      valid_r <= v_r[5] && q5_r;
    end
  end
  // v_r[k] qualifies the registers tagged qk; the vertical products stage
  // feeds the output register
  assign out_ch.valid = valid_r;
  assign out_ch.height = h_r;
endmodule
